// File: rtl/core/uart_rx_tx_ring_buffers_unit_assert.svh
// Assertion macros shared by the RTL that checks itself.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_ASSERT_SVH

// Property that must hold on every edge outside reset
`define URTRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition on one edge implies a consequence on the next edge
`define URTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/urtrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package urtrb_pkg;

	// Stream payload widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int BYTE_W      = 8;
	localparam int FILL_W      = 5;

	// Command codes carried in the low bits of the input tdata
	typedef enum logic [2:0] {
		CMD_TX_WRITE = 3'd0,
		CMD_RX_READ  = 3'd1,
		CMD_RX_BYTE  = 3'd2,
		CMD_TX_READY = 3'd3,
		CMD_CLR_RX   = 3'd4,
		CMD_CLR_TX   = 3'd5
	} cmd_t;

	// One operation on a ring, already qualified by the input transaction
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_op_t;

endpackage

`default_nettype wire

// File: rtl/core/urtrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module urtrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/urtrb_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module urtrb_ring #(
	parameter int DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire urtrb_pkg::ring_op_t          op,
	input  wire logic [urtrb_pkg::BYTE_W-1:0] wdata,
	output logic                              ok,
	output logic [$clog2(DEPTH+1)-1:0]        level,
	output logic [$clog2(DEPTH+1)-1:0]        level_nxt,
	output logic [urtrb_pkg::BYTE_W-1:0]      rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	logic [LW-1:0] level_q;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic          push_ok, pop_ok;

	assign push_ok = op.push && (level_q != LW'(DEPTH));
	assign pop_ok  = op.pop && (level_q != '0);
	assign ok      = push_ok || pop_ok;
	assign level   = level_q;

	// Pointer and level update; clear wins
	always_comb begin
		level_nxt = level_q;
		head_d    = head_q;
		tail_d    = tail_q;
		priority if (op.clear) begin
			level_nxt = '0;
			head_d    = '0;
			tail_d    = '0;
		end else if (push_ok) begin
			level_nxt = level_q + LW'(1);
			tail_d    = (tail_q == AW'(DEPTH-1)) ? '0 : tail_q + AW'(1);
		end else if (pop_ok) begin
			level_nxt = level_q - LW'(1);
			head_d    = (head_q == AW'(DEPTH-1)) ? '0 : head_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			level_q <= level_nxt;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	// Byte storage: write at tail, read at head
	urtrb_ram #(
		.WIDTH(urtrb_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(tail_q),
		.wdata(wdata),
		.re   (pop_ok),
		.raddr(head_q),
		.rdata(rdata)
	);

endmodule

`default_nettype wire

// File: rtl/core/uart_rx_tx_ring_buffers_unit.sv
// UART byte buffering: a receive ring FIFO and a transmit ring FIFO.
// Input stream (s_axis): one command per transaction. Commands are tx write,
// rx read, rx byte arrived, tx ready, clear rx and clear tx; codes six and
// seven do nothing and report accepted 0.
// Output stream (m_axis): exactly one result per command, in order, carrying
// the accepted flag, popped bytes, the tx interrupt enable and both levels.
// Timing: the stage register, the ring pointers and the byte memory read
// data all update at the input transaction edge; the result register loads
// from the stage register once it is free, and m_axis_tvalid rises with it.
// Throughput: one command per cycle while m_axis_tready stays high; each ring
// has one write and one read port and a registered pointer update.
// Stall: if m_axis_tready stays low, the result register and the stage
// register fill, then s_axis_tready drops; nothing is lost or repeated.
// Reset: arst_n clears both FIFO levels and pointers, the tx interrupt enable
// and all valid flags. Stored bytes are not cleared; only written entries are
// ever read back.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_tx_ring_buffers_unit #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// command[2:0], data_in[10:3], uart_busy[11], zero [15:12]
	input  wire logic [urtrb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// accepted[0], read_byte[8:1], tx_byte[16:9], tx_byte_valid[17],
	// tx_irq_enable[18], rx_fill[23:19], tx_fill[28:24], zero [31:29]
	output logic [urtrb_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

	localparam int RX_LW = $clog2(RX_DEPTH+1);
	localparam int TX_LW = $clog2(TX_DEPTH+1);

	urtrb_pkg::cmd_t                 command;
	logic [urtrb_pkg::BYTE_W-1:0]    data_in;
	logic                            uart_busy;
	logic                            accept;
	logic                            out_free;
	urtrb_pkg::ring_op_t             rx_op, tx_op;
	logic                            rx_ok, tx_ok;
	logic [RX_LW-1:0]                rx_level, rx_level_nxt;
	logic [TX_LW-1:0]                tx_level, tx_level_nxt;
	logic [urtrb_pkg::BYTE_W-1:0]    rx_rdata, tx_rdata;
	logic                            accepted_d;
	logic                            irq_q, irq_d;

	logic                            valid_s1;
	logic                            accepted_s1, rx_pop_s1, tx_pop_s1, irq_s1;
	logic [urtrb_pkg::FILL_W-1:0]    rx_fill_s1, tx_fill_s1;
	logic [urtrb_pkg::BYTE_W-1:0]    read_byte, tx_byte;

	logic                            m_tvalid_q;
	logic [urtrb_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// Input field split
	assign command   = urtrb_pkg::cmd_t'(s_axis_tdata[2:0]);
	assign data_in   = s_axis_tdata[10:3];
	assign uart_busy = s_axis_tdata[11];

	// Handshake: the stage moves when the result register can take it
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Command decode into ring operations
	always_comb begin
		rx_op = '0;
		tx_op = '0;
		if (accept) begin
			unique case (command)
				urtrb_pkg::CMD_TX_WRITE: tx_op.push  = 1'b1;
				urtrb_pkg::CMD_RX_READ:  rx_op.pop   = 1'b1;
				urtrb_pkg::CMD_RX_BYTE:  rx_op.push  = 1'b1;
				urtrb_pkg::CMD_TX_READY: tx_op.pop   = 1'b1;
				urtrb_pkg::CMD_CLR_RX:   rx_op.clear = 1'b1;
				urtrb_pkg::CMD_CLR_TX:   tx_op.clear = 1'b1;
				default: ;
			endcase
		end
	end

	urtrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (rx_op),
		.wdata    (data_in),
		.ok       (rx_ok),
		.level    (rx_level),
		.level_nxt(rx_level_nxt),
		.rdata    (rx_rdata)
	);

	urtrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (tx_op),
		.wdata    (data_in),
		.ok       (tx_ok),
		.level    (tx_level),
		.level_nxt(tx_level_nxt),
		.rdata    (tx_rdata)
	);

	// Accepted flag and tx interrupt enable
	always_comb begin
		accepted_d = 1'b0;
		irq_d      = irq_q;
		unique case (command)
			urtrb_pkg::CMD_TX_WRITE: begin
				accepted_d = tx_ok;
				if (tx_level == '0 && !uart_busy) begin
					irq_d = 1'b1;
				end
			end
			urtrb_pkg::CMD_RX_READ,
			urtrb_pkg::CMD_RX_BYTE: accepted_d = rx_ok;
			urtrb_pkg::CMD_TX_READY: begin
				accepted_d = tx_ok;
				if (tx_level_nxt == '0) begin
					irq_d = 1'b0;
				end
			end
			urtrb_pkg::CMD_CLR_RX,
			urtrb_pkg::CMD_CLR_TX: accepted_d = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				irq_q <= irq_d;
			end
			if (s_axis_tready) begin
				valid_s1 <= accept;
			end
		end
	end

	// Stage register, aligned with the memory read data
	always_ff @(posedge clk) begin
		if (accept) begin
			accepted_s1 <= accepted_d;
			rx_pop_s1   <= rx_op.pop && rx_ok;
			tx_pop_s1   <= tx_op.pop && tx_ok;
			irq_s1      <= irq_d;
			rx_fill_s1  <= urtrb_pkg::FILL_W'(rx_level_nxt);
			tx_fill_s1  <= urtrb_pkg::FILL_W'(tx_level_nxt);
		end
	end

	assign read_byte = rx_pop_s1 ? rx_rdata : '0;
	assign tx_byte   = tx_pop_s1 ? tx_rdata : '0;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_tdata_q <= {3'b000, tx_fill_s1, rx_fill_s1, irq_s1, tx_pop_s1,
				tx_byte, read_byte, accepted_s1};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

`include "uart_rx_tx_ring_buffers_unit_assert.svh"

	`URTRB_ASSERT(a_rx_level_range, rx_level <= RX_LW'(RX_DEPTH), "rx level beyond depth")
	`URTRB_ASSERT(a_tx_level_range, tx_level <= TX_LW'(TX_DEPTH), "tx level beyond depth")
	`URTRB_ASSERT(a_txv_implies_acc, !m_axis_tvalid || !m_axis_tdata[17] || m_axis_tdata[0], "tx byte valid without accepted")
	`URTRB_ASSERT_NEXT(a_clr_rx_empties, accept && command == urtrb_pkg::CMD_CLR_RX, rx_level == '0, "rx clear left bytes")

endmodule

`default_nettype wire
